// ===== src/ecp_pkg.sv =====
// Shared widths, word types and register codes for the ellipse outline column point block.
// No dependencies; every other file of the block imports this package.
package ecp_pkg;

    localparam int OFF_W      = 9;
    localparam int COORD_W    = 16;
    localparam int AXIS_W     = 8;
    localparam int SQ_W       = 2 * AXIS_W;
    localparam int MAG_W      = OFF_W;
    localparam int MSQ_W      = 2 * MAG_W;
    localparam int NUM_W      = MSQ_W + SQ_W;
    localparam int QUO_W      = SQ_W;
    localparam int REM_W      = SQ_W + QUO_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int CFG_DATA_W = COORD_W;

    typedef logic signed [OFF_W-1:0]   off_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [AXIS_W-1:0]         axis_t;
    typedef logic [SQ_W-1:0]           sq_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [MSQ_W-1:0]          msq_t;
    typedef logic [NUM_W-1:0]          num_t;
    typedef logic [REM_W-1:0]          rem_t;

    localparam axis_t MAX_HALF_AXIS = 8'd255;

    typedef enum logic [1:0] {
        CFG_CENTER_X    = 2'd0,
        CFG_CENTER_Y    = 2'd1,
        CFG_HALF_WIDTH  = 2'd2,
        CFG_HALF_HEIGHT = 2'd3
    } cfg_index_t;

    // dividend headed for the divider
    typedef struct packed {
        logic valid;
        num_t num;
        off_t off;
    } num_word_t;

    // quotient with its overflow flag headed for the root unit
    typedef struct packed {
        logic valid;
        logic ovf;
        sq_t  quo;
        off_t off;
    } div_word_t;

    // finished root headed for the output stage
    typedef struct packed {
        logic  valid;
        axis_t root;
        off_t  off;
    } root_word_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y_below;
        coord_t point_y_above;
        axis_t  arc_height;
    } out_word_t;

endpackage

// ===== src/ecp_in_if.sv =====
// Input channel: one column offset per word, valid/ready handshake.
// Depends on ecp_pkg.
interface ecp_in_if;
    import ecp_pkg::*;

    logic valid;
    logic ready;
    off_t column_offset;

    modport source (output valid, output column_offset, input ready);
    modport sink   (input valid, input column_offset, output ready);
endinterface

// ===== src/ecp_out_if.sv =====
// Output channel: one pair of outline points per word, valid/ready handshake.
// Depends on ecp_pkg.
interface ecp_out_if;
    import ecp_pkg::*;

    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y_below;
    coord_t point_y_above;
    axis_t  arc_height;

    modport source (output valid, output point_x, output point_y_below,
                    output point_y_above, output arc_height, input ready);
    modport sink   (input valid, input point_x, input point_y_below,
                    input point_y_above, input arc_height, output ready);
endinterface

// ===== src/ecp_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, overflow flagged when the quotient exceeds QUO_W bits.
// Depends on ecp_pkg.
module ecp_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  ecp_pkg::sq_t      den,
    input  ecp_pkg::num_word_t src,
    output ecp_pkg::div_word_t dst
);
    import ecp_pkg::*;

    logic [DIV_STEPS:0] vld_reg;
    logic               ovf_reg [DIV_STEPS+1];
    rem_t               rem_reg [DIV_STEPS+1];
    sq_t                quo_reg [DIV_STEPS+1];
    off_t               off_reg [DIV_STEPS+1];

    logic ovf_next;

    // quotient does not fit when num >= den * 2^QUO_W
    assign ovf_next = src.num >= NUM_W'({den, {QUO_W{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DIV_STEPS-1:0], src.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ovf_reg[0] <= ovf_next;
            rem_reg[0] <= src.num[REM_W-1:0];
            quo_reg[0] <= '0;
            off_reg[0] <= src.off;
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_step
        localparam int SH = DIV_STEPS - j;
        rem_t dsh;
        logic fit;

        assign dsh = rem_t'(den) << SH;
        assign fit = rem_reg[j-1] >= dsh;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ovf_reg[j] <= ovf_reg[j-1];
                rem_reg[j] <= fit ? rem_reg[j-1] - dsh : rem_reg[j-1];
                quo_reg[j] <= quo_reg[j-1] | (sq_t'(fit) << SH);
                off_reg[j] <= off_reg[j-1];
            end
        end
    end

    assign dst.valid = vld_reg[DIV_STEPS];
    assign dst.ovf   = ovf_reg[DIV_STEPS];
    assign dst.quo   = quo_reg[DIV_STEPS];
    assign dst.off   = off_reg[DIV_STEPS];

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DIV_STEPS] && !ovf_reg[DIV_STEPS]) |-> (rem_reg[DIV_STEPS] < rem_t'(den)))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== src/ecp_sqrt.sv =====
// Squared height clamp followed by a pipelined digit-by-digit floor square root.
// Depends on ecp_pkg.
module ecp_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  ecp_pkg::sq_t       hh2,
    input  ecp_pkg::div_word_t src,
    output ecp_pkg::root_word_t dst
);
    import ecp_pkg::*;

    logic [SQRT_STEPS:0] vld_reg;
    sq_t                 rem_reg  [SQRT_STEPS+1];
    sq_t                 root_reg [SQRT_STEPS+1];
    off_t                off_reg  [SQRT_STEPS+1];

    sq_t val_next;

    // squared height is hh2 - quo when there is no overflow and it is positive, else zero
    assign val_next = (!src.ovf && (src.quo < hh2)) ? hh2 - src.quo : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[SQRT_STEPS-1:0], src.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= val_next;
            root_reg[0] <= '0;
            off_reg[0]  <= src.off;
        end
    end

    for (genvar j = 1; j <= SQRT_STEPS; j++)
    begin : g_step
        localparam int BIT_POS = 2 * (SQRT_STEPS - j);
        logic [SQ_W:0] trial;
        logic          take;

        assign trial = {1'b0, root_reg[j-1]} + ((SQ_W+1)'(1) << BIT_POS);
        assign take  = {1'b0, rem_reg[j-1]} >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j]  <= take ? rem_reg[j-1] - trial[SQ_W-1:0] : rem_reg[j-1];
                root_reg[j] <= take ? (root_reg[j-1] >> 1) + (sq_t'(1) << BIT_POS)
                                    : (root_reg[j-1] >> 1);
                off_reg[j]  <= off_reg[j-1];
            end
        end
    end

    assign dst.valid = vld_reg[SQRT_STEPS];
    assign dst.root  = root_reg[SQRT_STEPS][AXIS_W-1:0];
    assign dst.off   = off_reg[SQRT_STEPS];

`ifndef SYNTHESIS
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SQRT_STEPS] |->
            ({1'b0, rem_reg[SQRT_STEPS]} <= {root_reg[SQRT_STEPS], 1'b0}))
        else $error("square root leftover exceeds twice the root");

    a_root_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SQRT_STEPS] |-> (root_reg[SQRT_STEPS][SQ_W-1:AXIS_W] == '0))
        else $error("square root wider than the half axis");
`endif

endmodule

// ===== src/ellipse_outline_column_points.sv =====
// Ellipse outline column points: for each column offset word the block returns the column x
// and the outline y below and above the centre. One word enters per clock while input ready
// is high; the accepting edge loads the first of two multiply stages, and the word then passes
// the second, a 17-stage restoring divider (a load stage, then one quotient bit per stage),
// a 9-stage square root (a load stage, then one root bit per stage) and the output register.
// The output register is backed by one skid entry, so input ready drops only once both hold
// an untaken result. Configuration writes go through cfg_we/cfg_index/cfg_data and must be
// made while no word is in flight; a half width of zero acts as one, and offsets at or beyond
// the half width give a zero arc height.
// Depends on ecp_pkg, ecp_in_if, ecp_out_if, ecp_divider and ecp_sqrt.
module ellipse_outline_column_points (
    input  logic                            clk,
    input  logic                            rst_n,
    ecp_in_if.sink                          column,
    ecp_out_if.source                       point,
    input  logic                            cfg_we,
    input  ecp_pkg::cfg_index_t             cfg_index,
    input  logic [ecp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ecp_pkg::*;

    coord_t center_x_reg;
    coord_t center_y_reg;
    sq_t    hh2_reg;
    sq_t    den_reg;

    axis_t  cfg_axis;
    sq_t    cfg_axis_sq;

    logic   adv;
    logic   take;
    mag_t   mag;
    msq_t   msq;

    logic   s1_vld_reg;
    msq_t   s1_msq_reg;
    off_t   s1_off_reg;
    logic   s2_vld_reg;
    num_t   s2_num_reg;
    off_t   s2_off_reg;

    num_word_t  num_word;
    div_word_t  div_word;
    root_word_t root_word;

    axis_t      arc;
    out_word_t  res;
    logic       pop;
    logic       out_valid_reg;
    out_word_t  out_data_reg;
    logic       skid_valid_reg;
    out_word_t  skid_data_reg;

    // configuration: keep squares of the half axes, ready for the datapath
    assign cfg_axis    = cfg_data[AXIS_W-1:0];
    assign cfg_axis_sq = sq_t'(cfg_axis) * sq_t'(cfg_axis);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            den_reg      <= sq_t'(1);
            hh2_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X:    center_x_reg <= coord_t'(cfg_data);
                CFG_CENTER_Y:    center_y_reg <= coord_t'(cfg_data);
                CFG_HALF_WIDTH:  den_reg      <= (cfg_axis == '0) ? sq_t'(1) : cfg_axis_sq;
                CFG_HALF_HEIGHT: hh2_reg      <= cfg_axis_sq;
                default:         ;
            endcase
        end
    end

    // the whole pipe advances unless the skid entry is occupied
    assign adv          = !skid_valid_reg;
    assign column.ready = adv;
    assign take         = column.valid && column.ready;

    assign mag = column.column_offset[OFF_W-1] ? mag_t'(-column.column_offset)
                                               : mag_t'(column.column_offset);
    assign msq = msq_t'(mag) * msq_t'(mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= take;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_msq_reg <= msq;
            s1_off_reg <= column.column_offset;
            s2_num_reg <= num_t'(s1_msq_reg) * num_t'(hh2_reg);
            s2_off_reg <= s1_off_reg;
        end
    end

    assign num_word.valid = s2_vld_reg;
    assign num_word.num   = s2_num_reg;
    assign num_word.off   = s2_off_reg;

    ecp_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .den   (den_reg),
        .src   (num_word),
        .dst   (div_word)
    );

    ecp_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .hh2   (hh2_reg),
        .src   (div_word),
        .dst   (root_word)
    );

    assign arc = (root_word.root > MAX_HALF_AXIS) ? MAX_HALF_AXIS : root_word.root;

    assign res.point_x       = center_x_reg + coord_t'(root_word.off);
    assign res.point_y_below = center_y_reg + coord_t'(arc);
    assign res.point_y_above = center_y_reg - coord_t'(arc);
    assign res.arc_height    = arc;

    assign pop = out_valid_reg && point.ready;

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg <= root_word.valid;
        end
        else if (root_word.valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_data_reg <= res;
        end
        else if (root_word.valid)
        begin
            skid_data_reg <= res;
        end
    end

    assign point.valid         = out_valid_reg;
    assign point.point_x       = out_data_reg.point_x;
    assign point.point_y_below = out_data_reg.point_y_below;
    assign point.point_y_above = out_data_reg.point_y_above;
    assign point.arc_height    = out_data_reg.arc_height;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_span_matches_arc: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid |-> (COORD_W'(point.point_y_below - point.point_y_above)
                         == COORD_W'({point.arc_height, 1'b0})))
        else $error("outline span does not match twice the arc height");
`endif

endmodule
